### src/pfa_pkg.sv
// Package for the partition fit allocator: opcodes, status codes, field widths
// and the sequencer state type. No dependencies.
package pfa_pkg;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_FIRST    = 3'd1,
    OP_BEST     = 3'd2,
    OP_WORST    = 3'd3,
    OP_FREE     = 3'd4,
    OP_COALESCE = 3'd5,
    OP_READ     = 3'd6,
    OP_NOP      = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_NOOWNER  = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADINDEX = 3'd4
  } status_e;

  localparam int unsigned OwnerBits = 16;
  localparam int unsigned ReqBits   = 16;
  localparam int unsigned SelBits   = 6;
  localparam int unsigned PosBits   = 6;
  localparam int unsigned CountBits = 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT,
    S_FREE_RD,
    S_FREE,
    S_COAL_RD,
    S_COAL,
    S_READ,
    S_DONE
  } state_e;

endpackage

### src/pfa_if.sv
// Valid/ready channel interfaces for the partition fit allocator.
// Depends on pfa_pkg.
interface pfa_req_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   opcode;
  logic [pfa_pkg::OwnerBits-1:0] owner_id;
  logic [pfa_pkg::ReqBits-1:0]   request_size;
  logic [pfa_pkg::SelBits-1:0]   entry_select;
  modport source (output valid, opcode, owner_id, request_size, entry_select, input ready);
  modport sink   (input valid, opcode, owner_id, request_size, entry_select, output ready);
endinterface

interface pfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [pfa_pkg::PosBits-1:0]    entry_position;
  logic                           entry_used;
  logic [pfa_pkg::OwnerBits-1:0]  entry_owner;
  logic [pfa_pkg::ReqBits-1:0]    entry_size;
  logic [pfa_pkg::CountBits-1:0]  segment_count;
  modport source (output valid, status, entry_position, entry_used, entry_owner, entry_size,
                  segment_count, input ready);
  modport sink   (input valid, status, entry_position, entry_used, entry_owner, entry_size,
                  segment_count, output ready);
endinterface

### src/pfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/partition_fit_allocator.sv
// Partition fit allocator: one entry RAM plus a sequencer that scans, shifts
// and compacts it one entry per cycle. Depends on pfa_pkg, pfa_if, pfa_ram.
//
// Each operation takes one command transfer and returns one result transfer.
// The segment table lives in a single RAM of MaxSegments words {used, owner,
// size}, read through a registered port, and the sequencer touches one entry
// per cycle. Append, opcode 7 and an out-of-range read finish without a scan;
// a valid read waits for its registered read data; free and coalesce walk
// every entry; an allocation scans the table (first fit stops at the first
// segment that fits) and then, when the chosen segment is split, shifts the
// entries above it up by one. The next command can be taken in the cycle
// after the result transfer.
module partition_fit_allocator #(
  parameter int unsigned MaxSegments = 64,
  parameter int unsigned SizeBits    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pfa_req_if.sink  req_i,
  pfa_rsp_if.source rsp_o
);
  localparam int unsigned AW = $clog2(MaxSegments);
  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam int unsigned EW = 1 + pfa_pkg::OwnerBits + SizeBits;

  typedef logic [SizeBits-1:0] size_t;

  pfa_pkg::state_e state_q, state_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] idx_q, idx_d;      // read pointer
  logic [CW-1:0] wr_q, wr_d;        // write pointer / shift target
  logic [AW-1:0] pick_q, pick_d;
  logic          found_q, found_d;
  size_t         pick_size_q, pick_size_d;
  logic          hit_q, hit_d;
  // last written entry during coalesce
  logic          last_used_q, last_used_d;
  size_t         last_size_q, last_size_d;
  logic [pfa_pkg::OwnerBits-1:0] last_own_q, last_own_d;
  // latched command
  logic [2:0]    op_q, op_d;
  logic [pfa_pkg::OwnerBits-1:0] own_q, own_d;
  size_t         req_q, req_d;
  logic [pfa_pkg::SelBits-1:0] sel_q, sel_d;
  // result register
  logic          rv_q, rv_d;
  logic [2:0]    rst_q, rst_d;
  logic [pfa_pkg::PosBits-1:0] rpos_q, rpos_d;
  logic          rused_q, rused_d;
  logic [pfa_pkg::OwnerBits-1:0] rown_q, rown_d;
  logic [pfa_pkg::ReqBits-1:0]   rsize_q, rsize_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic          r_used;
  logic [pfa_pkg::OwnerBits-1:0] r_own;
  size_t         r_size;
  logic [SizeBits:0] sum;

  pfa_ram #(.Width(EW), .Depth(MaxSegments)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign {r_used, r_own, r_size} = rdata;
  assign sum = {1'b0, last_size_q} + {1'b0, r_size};

  assign req_i.ready          = (state_q == pfa_pkg::S_IDLE) && !rv_q;
  assign rsp_o.valid          = rv_q;
  assign rsp_o.status         = rst_q;
  assign rsp_o.entry_position = rpos_q;
  assign rsp_o.entry_used     = rused_q;
  assign rsp_o.entry_owner    = rown_q;
  assign rsp_o.entry_size     = rsize_q;
  assign rsp_o.segment_count  = pfa_pkg::CountBits'(total_q);

  // Control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::S_IDLE;
      total_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; wr_q <= wr_d; pick_q <= pick_d; found_q <= found_d;
    pick_size_q <= pick_size_d; hit_q <= hit_d;
    last_used_q <= last_used_d; last_size_q <= last_size_d; last_own_q <= last_own_d;
    op_q <= op_d; own_q <= own_d; req_q <= req_d; sel_q <= sel_d;
    rst_q <= rst_d; rpos_q <= rpos_d; rused_q <= rused_d; rown_q <= rown_d;
    rsize_q <= rsize_d;
  end

  // Sequencer: next state, RAM access and result
  always_comb begin
    logic fits;
    logic better;
    state_d = state_q; total_d = total_q; idx_d = idx_q; wr_d = wr_q;
    pick_d = pick_q; found_d = found_q; pick_size_d = pick_size_q; hit_d = hit_q;
    last_used_d = last_used_q; last_size_d = last_size_q; last_own_d = last_own_q;
    op_d = op_q; own_d = own_q; req_d = req_q; sel_d = sel_q;
    rv_d = rv_q; rst_d = rst_q; rpos_d = rpos_q; rused_d = rused_q;
    rown_d = rown_q; rsize_d = rsize_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = AW'(idx_q);
    fits = !r_used && (r_size >= req_q);
    better = 1'b0;

    if (rv_q && rsp_o.ready) rv_d = 1'b0;

    case (state_q)
      pfa_pkg::S_IDLE: begin
        if (req_i.valid && !rv_q) begin
          op_d  = req_i.opcode;
          own_d = req_i.owner_id;
          req_d = SizeBits'(req_i.request_size);
          sel_d = req_i.entry_select;
          idx_d = '0; wr_d = '0; found_d = 1'b0; hit_d = 1'b0;
          rst_d = pfa_pkg::ST_OK; rpos_d = '0; rused_d = 1'b0; rown_d = '0; rsize_d = '0;
          case (pfa_pkg::opcode_e'(req_i.opcode))
            pfa_pkg::OP_APPEND: begin
              if (total_q >= CW'(MaxSegments)) begin
                rst_d = pfa_pkg::ST_FULL;
              end else begin
                we = 1'b1; waddr = AW'(total_q);
                wdata = {1'b0, {pfa_pkg::OwnerBits{1'b0}}, SizeBits'(req_i.request_size)};
                rpos_d = pfa_pkg::PosBits'(total_q);
                rsize_d = pfa_pkg::ReqBits'(SizeBits'(req_i.request_size));
                total_d = total_q + 1'b1;
              end
              state_d = pfa_pkg::S_DONE;
            end
            pfa_pkg::OP_FIRST, pfa_pkg::OP_BEST, pfa_pkg::OP_WORST: begin
              state_d = pfa_pkg::S_SCAN_RD;
            end
            pfa_pkg::OP_FREE:     state_d = pfa_pkg::S_FREE_RD;
            pfa_pkg::OP_COALESCE: state_d = pfa_pkg::S_COAL_RD;
            pfa_pkg::OP_READ: begin
              // issue the read of the selected entry now
              raddr = AW'(req_i.entry_select);
              if (CW'(req_i.entry_select) >= total_q || CW'(req_i.entry_select) >=
                  CW'(MaxSegments)) begin
                rst_d = pfa_pkg::ST_BADINDEX;
                state_d = pfa_pkg::S_DONE;
              end else begin
                state_d = pfa_pkg::S_READ;
              end
            end
            default: state_d = pfa_pkg::S_DONE;
          endcase
        end
      end

      pfa_pkg::S_READ: begin
        rpos_d = sel_q; rused_d = r_used; rown_d = r_own;
        rsize_d = pfa_pkg::ReqBits'(r_size);
        state_d = pfa_pkg::S_DONE;
      end
      // read issue states
      pfa_pkg::S_SCAN_RD, pfa_pkg::S_FREE_RD, pfa_pkg::S_COAL_RD: begin
        if (idx_q >= total_q) begin
          // empty table
          if (state_q == pfa_pkg::S_SCAN_RD) rst_d = pfa_pkg::ST_NOFIT;
          if (state_q == pfa_pkg::S_FREE_RD) rst_d = pfa_pkg::ST_NOOWNER;
          if (state_q == pfa_pkg::S_COAL_RD) total_d = '0;
          state_d = pfa_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
          case (state_q)
            pfa_pkg::S_SCAN_RD: state_d = pfa_pkg::S_SCAN;
            pfa_pkg::S_FREE_RD: state_d = pfa_pkg::S_FREE;
            default:            state_d = pfa_pkg::S_COAL;
          endcase
        end
      end

      // entry idx_q-1 in rdata; idx_q being read
      pfa_pkg::S_SCAN: begin
        if (op_q == 3'(pfa_pkg::OP_BEST))  better = r_size < pick_size_q;
        if (op_q == 3'(pfa_pkg::OP_WORST)) better = r_size > pick_size_q;
        if (fits && (!found_q || better)) begin
          found_d = 1'b1; pick_d = AW'(idx_q - 1'b1); pick_size_d = r_size;
        end
        if ((fits && op_q == 3'(pfa_pkg::OP_FIRST)) || idx_q >= total_q) begin
          if (!(found_q || fits)) begin
            rst_d = pfa_pkg::ST_NOFIT; state_d = pfa_pkg::S_DONE;
          end else begin
            state_d = pfa_pkg::S_SHIFT_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // decide split; start shifting from the top
      pfa_pkg::S_SHIFT_RD: begin
        rst_d = pfa_pkg::ST_OK;
        if (pick_size_q == req_q) begin
          we = 1'b1; waddr = pick_q; wdata = {1'b1, own_q, req_q};
          rpos_d = pfa_pkg::PosBits'(pick_q); rused_d = 1'b1; rown_d = own_q;
          rsize_d = pfa_pkg::ReqBits'(req_q);
          state_d = pfa_pkg::S_DONE;
        end else if (total_q >= CW'(MaxSegments)) begin
          rst_d = pfa_pkg::ST_FULL; state_d = pfa_pkg::S_DONE;
        end else begin
          // wr = destination; read wr-1
          wr_d = total_q;
          raddr = AW'(total_q - 1'b1);
          state_d = pfa_pkg::S_SHIFT;
        end
      end

      // rdata holds entry wr_q-1
      pfa_pkg::S_SHIFT: begin
        if (wr_q > CW'(pick_q) + 1'b1) begin
          we = 1'b1; waddr = AW'(wr_q); wdata = rdata;
          wr_d = wr_q - 1'b1;
          raddr = AW'(wr_q - 2'd2);
        end else begin
          // write remainder, then the allocation into pick (next cycle via hit)
          if (!hit_q) begin
            we = 1'b1; waddr = AW'(CW'(pick_q) + 1'b1);
            wdata = {1'b0, {pfa_pkg::OwnerBits{1'b0}}, pick_size_q - req_q};
            hit_d = 1'b1;
          end else begin
            we = 1'b1; waddr = pick_q; wdata = {1'b1, own_q, req_q};
            total_d = total_q + 1'b1;
            rpos_d = pfa_pkg::PosBits'(pick_q); rused_d = 1'b1; rown_d = own_q;
            rsize_d = pfa_pkg::ReqBits'(req_q);
            state_d = pfa_pkg::S_DONE;
          end
        end
      end

      pfa_pkg::S_FREE: begin
        if (r_used && r_own == own_q) begin
          we = 1'b1; waddr = AW'(idx_q - 1'b1);
          wdata = {1'b0, {pfa_pkg::OwnerBits{1'b0}}, r_size};
          hit_d = 1'b1;
        end
        if (idx_q >= total_q) begin
          rst_d = (hit_d) ? pfa_pkg::ST_OK : pfa_pkg::ST_NOOWNER;
          state_d = pfa_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // write pointer trails the read pointer, so reads never see stale data
      pfa_pkg::S_COAL: begin
        if (wr_q != '0 && !r_used && !last_used_q) begin
          last_size_d = sum[SizeBits] ? {SizeBits{1'b1}} : sum[SizeBits-1:0];
          we = 1'b1; waddr = AW'(wr_q - 1'b1);
          wdata = {last_used_q, last_own_q, last_size_d};
        end else begin
          we = 1'b1; waddr = AW'(wr_q); wdata = rdata;
          last_used_d = r_used; last_own_d = r_own; last_size_d = r_size;
          wr_d = wr_q + 1'b1;
        end
        if (idx_q >= total_q) begin
          total_d = wr_d;
          state_d = pfa_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      pfa_pkg::S_DONE: begin
        rv_d = 1'b1;
        state_d = pfa_pkg::S_IDLE;
      end

      default: state_d = pfa_pkg::S_IDLE;
    endcase
  end
endmodule

### bench/pfa_bench_if.sv
// Bench-side note: the channel interfaces come from src/pfa_if.sv.
// This file holds the small helper package of shared bench constants.
// No dependencies.
package pfa_bench_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned MaxLatency = 2 * TableDepth + 6;
endpackage

### bench/pfa_checker.sv
// Checker for the partition fit allocator: watches both channels, keeps a
// shadow segment table, predicts each result and compares field by field.
// Depends on pfa_pkg, pfa_bench_pkg and the pfa channel interfaces.
module pfa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfa_req_if          req,
  pfa_rsp_if          rsp,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    pfa_pkg::status_e                status;
    logic [pfa_pkg::PosBits-1:0]     position;
    logic                            used;
    logic [pfa_pkg::OwnerBits-1:0]   owner;
    logic [pfa_pkg::ReqBits-1:0]     size;
    logic [pfa_pkg::CountBits-1:0]   count;
  } result_t;

  logic [pfa_pkg::ReqBits-1:0]   seg_size  [pfa_bench_pkg::TableDepth];
  logic                          seg_used  [pfa_bench_pkg::TableDepth];
  logic [pfa_pkg::OwnerBits-1:0] seg_owner [pfa_bench_pkg::TableDepth];
  int unsigned                   seg_count;

  result_t expected_q[$];
  int unsigned fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_q.size();

  function automatic result_t show_entry(pfa_pkg::status_e st, int unsigned pos, bit show);
    result_t r;
    r = '0;
    r.status = st;
    if (show && pos < seg_count) begin
      r.position = pos[pfa_pkg::PosBits-1:0];
      r.used     = seg_used[pos];
      r.owner    = seg_owner[pos];
      r.size     = seg_size[pos];
    end
    r.count = seg_count[pfa_pkg::CountBits-1:0];
    return r;
  endfunction

  function automatic result_t fit_allocate(pfa_pkg::opcode_e op,
                                           logic [pfa_pkg::OwnerBits-1:0] owner,
                                           logic [pfa_pkg::ReqBits-1:0] amount);
    int unsigned pick;
    bit found;
    found = 0;
    pick = 0;
    for (int unsigned i = 0; i < seg_count; i++) begin
      if (seg_used[i] || seg_size[i] < amount) continue;
      if (!found) begin
        pick = i;
        found = 1;
        if (op == pfa_pkg::OP_FIRST) break;
      end else if (op == pfa_pkg::OP_BEST && seg_size[i] < seg_size[pick]) begin
        pick = i;
      end else if (op == pfa_pkg::OP_WORST && seg_size[i] > seg_size[pick]) begin
        pick = i;
      end
    end
    if (!found) return show_entry(pfa_pkg::ST_NOFIT, 0, 0);
    if (seg_size[pick] != amount) begin
      if (seg_count >= pfa_bench_pkg::TableDepth) return show_entry(pfa_pkg::ST_FULL, 0, 0);
      for (int unsigned i = seg_count; i > pick + 1; i--) begin
        seg_size[i]  = seg_size[i-1];
        seg_used[i]  = seg_used[i-1];
        seg_owner[i] = seg_owner[i-1];
      end
      seg_size[pick+1]  = seg_size[pick] - amount;
      seg_used[pick+1]  = 0;
      seg_owner[pick+1] = '0;
      seg_count++;
    end
    seg_size[pick]  = amount;
    seg_used[pick]  = 1;
    seg_owner[pick] = owner;
    return show_entry(pfa_pkg::ST_OK, pick, 1);
  endfunction

  function automatic result_t predict_result(pfa_pkg::opcode_e op,
                                             logic [pfa_pkg::OwnerBits-1:0] owner,
                                             logic [pfa_pkg::ReqBits-1:0] amount,
                                             logic [pfa_pkg::SelBits-1:0] sel);
    pfa_pkg::status_e st;
    int unsigned wr;
    int unsigned sum;
    case (op)
      pfa_pkg::OP_APPEND: begin
        if (seg_count >= pfa_bench_pkg::TableDepth) return show_entry(pfa_pkg::ST_FULL, 0, 0);
        seg_size[seg_count]  = amount;
        seg_used[seg_count]  = 0;
        seg_owner[seg_count] = '0;
        seg_count++;
        return show_entry(pfa_pkg::ST_OK, seg_count - 1, 1);
      end
      pfa_pkg::OP_FIRST, pfa_pkg::OP_BEST, pfa_pkg::OP_WORST:
        return fit_allocate(op, owner, amount);
      pfa_pkg::OP_FREE: begin
        st = pfa_pkg::ST_NOOWNER;
        for (int unsigned i = 0; i < seg_count; i++) begin
          if (seg_used[i] && seg_owner[i] == owner) begin
            seg_used[i]  = 0;
            seg_owner[i] = '0;
            st = pfa_pkg::ST_OK;
          end
        end
        return show_entry(st, 0, 0);
      end
      pfa_pkg::OP_COALESCE: begin
        wr = 0;
        for (int unsigned rd = 0; rd < seg_count; rd++) begin
          if (wr > 0 && !seg_used[rd] && !seg_used[wr-1]) begin
            sum = seg_size[wr-1] + seg_size[rd];
            seg_size[wr-1] = (sum > 16'hFFFF) ? 16'hFFFF : sum[pfa_pkg::ReqBits-1:0];
          end else begin
            seg_size[wr]  = seg_size[rd];
            seg_used[wr]  = seg_used[rd];
            seg_owner[wr] = seg_owner[rd];
            wr++;
          end
        end
        seg_count = wr;
        return show_entry(pfa_pkg::ST_OK, 0, 0);
      end
      pfa_pkg::OP_READ: begin
        if (sel >= seg_count) return show_entry(pfa_pkg::ST_BADINDEX, 0, 0);
        return show_entry(pfa_pkg::ST_OK, sel, 1);
      end
      default: return show_entry(pfa_pkg::ST_OK, 0, 0);
    endcase
  endfunction

  // Predict on each command transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      seg_count  = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_q.push_back(predict_result(pfa_pkg::opcode_e'(req.opcode), req.owner_id,
                                            req.request_size, req.entry_select));
      end
      if (rsp.valid && rsp.ready) begin
        got.status   = pfa_pkg::status_e'(rsp.status);
        got.position = rsp.entry_position;
        got.used     = rsp.entry_used;
        got.owner    = rsp.entry_owner;
        got.size     = rsp.entry_size;
        got.count    = rsp.segment_count;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("checker: unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("checker: mismatch expected %p actual %p", want, got);
          end
        end
      end
    end
  end

endmodule

### bench/tb.sv
// Top of the partition fit allocator bench: clock, reset, stimulus and verdict.
// Depends on pfa_pkg, pfa_bench_pkg, the channel interfaces, pfa_checker and the allocator.
module tb;

  localparam int unsigned CycleLimit = 600000;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic [pfa_pkg::OwnerBits-1:0] owner_pool [4];

  pfa_req_if req ();
  pfa_rsp_if rsp ();

  partition_fit_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  pfa_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .rsp         (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver stalls at random
  always @(negedge clk_i) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold valid until the transfer; the next command or an idle cycle drops it
  task automatic send_cmd(pfa_pkg::opcode_e op, logic [pfa_pkg::OwnerBits-1:0] owner,
                          logic [pfa_pkg::ReqBits-1:0] amount,
                          logic [pfa_pkg::SelBits-1:0] sel);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid        <= 1'b1;
    req.opcode       <= op;
    req.owner_id     <= owner;
    req.request_size <= amount;
    req.entry_select <= sel;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [pfa_pkg::ReqBits-1:0] amount;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0: amount = pfa_pkg::ReqBits'($urandom);
      1: amount = pfa_pkg::ReqBits'($urandom_range(0, 15));
      default: amount = pfa_pkg::ReqBits'($urandom_range(0, 4000));
    endcase
    if (pick < 22)
      send_cmd(pfa_pkg::OP_APPEND, pfa_pkg::OwnerBits'($urandom), amount,
               pfa_pkg::SelBits'($urandom));
    else if (pick < 62)
      send_cmd(pfa_pkg::opcode_e'($urandom_range(pfa_pkg::OP_FIRST, pfa_pkg::OP_WORST)),
               ($urandom_range(9) == 0) ? pfa_pkg::OwnerBits'($urandom)
                                        : owner_pool[$urandom_range(3)],
               amount, pfa_pkg::SelBits'($urandom));
    else if (pick < 74)
      send_cmd(pfa_pkg::OP_FREE,
               ($urandom_range(7) == 0) ? pfa_pkg::OwnerBits'($urandom)
                                        : owner_pool[$urandom_range(3)],
               pfa_pkg::ReqBits'($urandom), pfa_pkg::SelBits'($urandom));
    else if (pick < 82)
      send_cmd(pfa_pkg::OP_COALESCE, pfa_pkg::OwnerBits'($urandom),
               pfa_pkg::ReqBits'($urandom), pfa_pkg::SelBits'($urandom));
    else if (pick < 98)
      send_cmd(pfa_pkg::OP_READ, pfa_pkg::OwnerBits'($urandom),
               pfa_pkg::ReqBits'($urandom), pfa_pkg::SelBits'($urandom));
    else
      send_cmd(pfa_pkg::OP_NOP, pfa_pkg::OwnerBits'($urandom),
               pfa_pkg::ReqBits'($urandom), pfa_pkg::SelBits'($urandom));
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 69;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.opcode = pfa_pkg::OP_NOP;
    req.owner_id = '0;
    req.request_size = '0;
    req.entry_select = '0;
    owner_pool[0] = 16'h0001;
    owner_pool[1] = 16'hFFFF;
    owner_pool[2] = 16'h5A5A;
    owner_pool[3] = 16'h0000;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-table cases, extremes, splits, ties, saturation, overflow
    send_cmd(pfa_pkg::OP_READ, 16'h0, 16'h0, 6'd0);
    send_cmd(pfa_pkg::OP_FIRST, 16'h1, 16'h0, 6'd0);
    send_cmd(pfa_pkg::OP_FREE, 16'h1, 16'h0, 6'd0);
    send_cmd(pfa_pkg::OP_APPEND, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_cmd(pfa_pkg::OP_APPEND, 16'h0, 16'hFFFF, 6'd0);
    send_cmd(pfa_pkg::OP_APPEND, 16'h0, 16'd100, 6'd0);
    send_cmd(pfa_pkg::OP_APPEND, 16'h0, 16'd100, 6'd0);
    send_cmd(pfa_pkg::OP_COALESCE, 16'h0, 16'h0, 6'd0);
    send_cmd(pfa_pkg::OP_APPEND, 16'h0, 16'd50, 6'd0);
    send_cmd(pfa_pkg::OP_APPEND, 16'h0, 16'd50, 6'd0);
    send_cmd(pfa_pkg::OP_BEST, 16'hFFFF, 16'd50, 6'd0);
    send_cmd(pfa_pkg::OP_WORST, 16'h1234, 16'd0, 6'd0);
    send_cmd(pfa_pkg::OP_FIRST, 16'h1234, 16'd10, 6'd0);
    send_cmd(pfa_pkg::OP_BEST, 16'h0001, 16'd20, 6'd0);
    send_cmd(pfa_pkg::OP_WORST, 16'h0001, 16'hFFFF, 6'd0);
    send_cmd(pfa_pkg::OP_READ, 16'h0, 16'h0, 6'd1);
    send_cmd(pfa_pkg::OP_READ, 16'h0, 16'h0, 6'h3F);
    send_cmd(pfa_pkg::OP_FREE, 16'h1234, 16'h0, 6'd0);
    send_cmd(pfa_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_cmd(pfa_pkg::OP_COALESCE, 16'h0, 16'h0, 6'd0);
    // Fill the table to force append and split overflow
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    for (int i = 0; i < 66; i++) send_cmd(pfa_pkg::OP_APPEND, 16'h0, 16'd8, 6'd0);
    send_cmd(pfa_pkg::OP_FIRST, 16'h7, 16'd3, 6'd0);
    send_cmd(pfa_pkg::OP_BEST, 16'h7, 16'd8, 6'd0);
    send_cmd(pfa_pkg::OP_READ, 16'h0, 16'h0, 6'h3F);
    send_cmd(pfa_pkg::OP_FREE, 16'h7, 16'h0, 6'd0);
    send_cmd(pfa_pkg::OP_COALESCE, 16'h0, 16'h0, 6'd0);

    // Random, over three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 29 : 0;
      for (int i = 0; i < 270; i++) send_random();
    end

    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (pfa_bench_pkg::MaxLatency) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
